FILE: rtl/core/infix_expression_evaluator_defines.svh
// Assertion macros used by the evaluator RTL.
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define IES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IES_ASSERT_IMP(lbl, ante, cons, msg)

`define IES_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/core/ies_pkg.sv
package ies_pkg;

  localparam int unsigned StackDepthDef = 32;
  localparam int unsigned ValueW        = 32;
  localparam int unsigned NumberW       = 31;
  localparam int unsigned OperW         = 3;

  typedef enum logic [2:0] {
    ACT_OPERAND = 3'd0,
    ACT_OPEN    = 3'd1,
    ACT_CLOSE   = 3'd2,
    ACT_OPER    = 3'd3,
    ACT_END     = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIV_ZERO  = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  // Operator stack entry for an open bracket; operators use codes 0..3.
  localparam logic [OperW-1:0] OperOpen = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_OTOP,
    S_RB,
    S_RA,
    S_DIV,
    S_WB,
    S_FINISH,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [ValueW-1:0] dividend;
    logic [ValueW-1:0] divisor;
  } div_req_t;

  function automatic logic high_prec(logic [1:0] op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction

endpackage

FILE: rtl/core/ies_ram.sv
module ies_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ies_div.sv
module ies_div
  import ies_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              done_o,
  output logic [ValueW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(ValueW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [ValueW-1:0] quo_q, quo_d;
  logic [ValueW-1:0] mb_q, mb_d;
  logic              neg_q, neg_d;

  logic [ValueW:0]   shifted;
  logic [ValueW:0]   diff;
  logic              last;

  assign shifted = {rem_q, quo_q[ValueW-1]};
  assign diff    = shifted - {1'b0, mb_q};
  assign last    = cnt_q == StepW'(ValueW - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend[ValueW-1] ? (ValueW'(0) - req_i.dividend) : req_i.dividend;
      mb_d   = req_i.divisor[ValueW-1] ? (ValueW'(0) - req_i.divisor) : req_i.divisor;
      neg_d  = req_i.dividend[ValueW-1] ^ req_i.divisor[ValueW-1];
    end else if (busy_q) begin
      // Restoring step: one quotient bit per cycle, MSB first.
      if (!diff[ValueW]) begin
        rem_d = diff[ValueW-1:0];
      end else begin
        rem_d = shifted[ValueW-1:0];
      end
      quo_d = {quo_q[ValueW-2:0], !diff[ValueW]};
      cnt_d = cnt_q + StepW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    mb_q  <= mb_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (ValueW'(0) - quo_q) : quo_q;

endmodule

FILE: rtl/core/infix_expression_evaluator.sv
// Two-stack infix expression evaluator.
// Input channel: one token per request (action_i, number_i, op_code_i) with
// in_valid_i / in_stall_o. Output channel: one result_o / status_o per end
// token with out_valid_o / out_stall_i. Both stacks live in single-port-read
// synchronous RAMs; the controller works on one token at a time.
// Each reduction pops the operator, reads the two values, executes and writes
// back; a divide runs in the radix-2 divider. End drains the operator stack,
// then finishes and emits its result.
// The result register decouples the output: tokens keep being taken while a
// result waits; an end token whose result slot is still full waits in its
// final state until the receiver drops out_stall_i.
// Reset clears both stack counts, the sticky error and the output valid; stack
// contents are not cleared and need no sweep. After the first error, tokens
// other than end are dropped until end reports the error.
`include "infix_expression_evaluator_defines.svh"

module infix_expression_evaluator
  import ies_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic [NumberW-1:0] number_i,
  input  logic [1:0]         op_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [ValueW-1:0] result_o,
  output logic [1:0]         status_o
);

  localparam int unsigned CountW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW  = $clog2(STACK_DEPTH);

  state_e state_q, state_d;

  logic [2:0]         tok_action_q, tok_action_d;
  logic [NumberW-1:0] tok_number_q, tok_number_d;
  logic [1:0]         tok_op_q, tok_op_d;

  logic [CountW-1:0]  vc_q, vc_d;
  logic [CountW-1:0]  oc_q, oc_d;
  status_e            err_q, err_d;
  status_e            stat_q, stat_d;
  op_e                red_op_q, red_op_d;
  logic [ValueW-1:0]  b_q, b_d;
  logic [ValueW-1:0]  r_q, r_d;

  logic               out_valid_q, out_valid_d;
  logic [ValueW-1:0]  result_q, result_d;
  status_e            status_q, status_d;

  logic               v_we, v_re;
  logic [AddrW-1:0]   v_waddr, v_raddr;
  logic [ValueW-1:0]  v_wdata, v_rdata;
  logic               o_we, o_re;
  logic [AddrW-1:0]   o_waddr, o_raddr;
  logic [OperW-1:0]   o_wdata, o_rdata;

  div_req_t           div_req;
  logic               div_done;
  logic [ValueW-1:0]  div_quot;

  logic [CountW-1:0]  vc_m1, vc_m2, oc_m1;
  logic               vc_full, oc_full, oc_zero, vc_lt2, b_zero;
  logic               top_open, top_reduces;
  logic               out_free, out_load;
  logic               is_end, is_close, is_oper;

  assign vc_m1    = vc_q - CountW'(1);
  assign vc_m2    = vc_q - CountW'(2);
  assign oc_m1    = oc_q - CountW'(1);
  assign vc_full  = vc_q == CountW'(STACK_DEPTH);
  assign oc_full  = oc_q == CountW'(STACK_DEPTH);
  assign oc_zero  = oc_q == '0;
  assign vc_lt2   = vc_q < CountW'(2);
  assign b_zero   = b_q == '0;
  assign is_end   = tok_action_q == ACT_END;
  assign is_close = tok_action_q == ACT_CLOSE;
  assign is_oper  = tok_action_q == ACT_OPER;

  // Top-of-stack decode, valid in S_OTOP.
  assign top_open    = o_rdata == OperOpen;
  assign top_reduces = !top_open && (high_prec(o_rdata[1:0]) || !high_prec(tok_op_q));

  assign out_free = !out_valid_q || !out_stall_i;

  ies_ram #(
    .Width(ValueW),
    .Depth(STACK_DEPTH)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(v_waddr),
    .wdata_i(v_wdata),
    .re_i   (v_re),
    .raddr_i(v_raddr),
    .rdata_o(v_rdata)
  );

  ies_ram #(
    .Width(OperW),
    .Depth(STACK_DEPTH)
  ) u_oper_ram (
    .clk_i  (clk_i),
    .we_i   (o_we),
    .waddr_i(o_waddr),
    .wdata_i(o_wdata),
    .re_i   (o_re),
    .raddr_i(o_raddr),
    .rdata_o(o_rdata)
  );

  ies_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (is_end) begin
          state_d = ((err_q != ST_OK) || oc_zero) ? S_FINISH : S_OTOP;
        end else if (err_q != ST_OK) begin
          state_d = S_IDLE;
        end else if (is_close || is_oper) begin
          state_d = oc_zero ? S_IDLE : S_OTOP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OTOP: begin
        priority if (is_end && top_open) begin
          state_d = S_FINISH;
        end else if (is_close && top_open) begin
          state_d = S_IDLE;
        end else if (is_oper && !top_reduces) begin
          state_d = S_IDLE;
        end else if (vc_lt2) begin
          state_d = S_DISPATCH;
        end else begin
          state_d = S_RB;
        end
      end
      S_RB: state_d = S_RA;
      S_RA: begin
        if (red_op_q == OP_DIV) begin
          state_d = b_zero ? S_DISPATCH : S_DIV;
        end else begin
          state_d = S_WB;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_WB;
        end
      end
      S_WB:     state_d = S_DISPATCH;
      S_FINISH: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    tok_action_d = tok_action_q;
    tok_number_d = tok_number_q;
    tok_op_d     = tok_op_q;
    vc_d         = vc_q;
    oc_d         = oc_q;
    err_d        = err_q;
    stat_d       = stat_q;
    red_op_d     = red_op_q;
    b_d          = b_q;
    r_d          = r_q;
    v_we         = 1'b0;
    v_waddr      = '0;
    v_wdata      = '0;
    v_re         = 1'b0;
    v_raddr      = '0;
    o_we         = 1'b0;
    o_waddr      = '0;
    o_wdata      = '0;
    o_re         = 1'b0;
    o_raddr      = '0;
    div_req      = '0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tok_action_d = action_i;
          tok_number_d = number_i;
          tok_op_d     = op_code_i;
        end
      end
      S_DISPATCH: begin
        priority if (is_end) begin
          if ((err_q == ST_OK) && !oc_zero) begin
            o_re    = 1'b1;
            o_raddr = oc_m1[AddrW-1:0];
          end
        end else if (err_q != ST_OK) begin
          // sticky error: token dropped
        end else begin
          unique case (tok_action_q)
            ACT_OPERAND: begin
              if (vc_full) begin
                err_d = ST_OVERFLOW;
              end else begin
                v_we    = 1'b1;
                v_waddr = vc_q[AddrW-1:0];
                v_wdata = {1'b0, tok_number_q};
                vc_d    = vc_q + CountW'(1);
              end
            end
            ACT_OPEN: begin
              if (oc_full) begin
                err_d = ST_OVERFLOW;
              end else begin
                o_we    = 1'b1;
                o_waddr = oc_q[AddrW-1:0];
                o_wdata = OperOpen;
                oc_d    = oc_q + CountW'(1);
              end
            end
            ACT_CLOSE: begin
              if (oc_zero) begin
                err_d = ST_MALFORMED;
              end else begin
                o_re    = 1'b1;
                o_raddr = oc_m1[AddrW-1:0];
              end
            end
            ACT_OPER: begin
              if (oc_zero) begin
                o_we    = 1'b1;
                o_waddr = oc_q[AddrW-1:0];
                o_wdata = {1'b0, tok_op_q};
                oc_d    = oc_q + CountW'(1);
              end else begin
                o_re    = 1'b1;
                o_raddr = oc_m1[AddrW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      S_OTOP: begin
        priority if (is_end && top_open) begin
          oc_d  = oc_m1;
          err_d = ST_MALFORMED;
        end else if (is_close && top_open) begin
          oc_d = oc_m1;
        end else if (is_oper && !top_reduces) begin
          if (oc_full) begin
            err_d = ST_OVERFLOW;
          end else begin
            o_we    = 1'b1;
            o_waddr = oc_q[AddrW-1:0];
            o_wdata = {1'b0, tok_op_q};
            oc_d    = oc_q + CountW'(1);
          end
        end else begin
          // pop the operator and start a reduction, or flag malformed with fewer than two values
          oc_d     = oc_m1;
          red_op_d = op_e'(o_rdata[1:0]);
          if (vc_lt2) begin
            err_d = ST_MALFORMED;
          end else begin
            v_re    = 1'b1;
            v_raddr = vc_m1[AddrW-1:0];
          end
        end
      end
      S_RB: begin
        b_d     = v_rdata;
        v_re    = 1'b1;
        v_raddr = vc_m2[AddrW-1:0];
      end
      S_RA: begin
        unique case (red_op_q)
          OP_ADD: r_d = v_rdata + b_q;
          OP_SUB: r_d = v_rdata - b_q;
          OP_MUL: r_d = ValueW'(v_rdata * b_q);
          OP_DIV: begin
            if (b_zero) begin
              err_d = ST_DIV_ZERO;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = v_rdata;
              div_req.divisor  = b_q;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          r_d = div_quot;
        end
      end
      S_WB: begin
        vc_d    = vc_m1;
        v_we    = 1'b1;
        v_waddr = vc_m2[AddrW-1:0];
        v_wdata = r_q;
      end
      S_FINISH: begin
        if (err_q != ST_OK) begin
          stat_d = err_q;
        end else if (vc_q != CountW'(1)) begin
          stat_d = ST_MALFORMED;
        end else begin
          stat_d = ST_OK;
        end
        v_re    = 1'b1;
        v_raddr = '0;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          vc_d     = '0;
          oc_d     = '0;
          err_d    = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    result_d    = result_q;
    status_d    = status_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      result_d    = (stat_q == ST_OK) ? v_rdata : '0;
      status_d    = stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vc_q        <= '0;
      oc_q        <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vc_q        <= vc_d;
      oc_q        <= oc_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_action_q <= tok_action_d;
    tok_number_q <= tok_number_d;
    tok_op_q     <= tok_op_d;
    stat_q       <= stat_d;
    red_op_q     <= red_op_d;
    b_q          <= b_d;
    r_q          <= r_d;
    result_q     <= result_d;
    status_q     <= status_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign status_o    = status_q;

  `IES_ASSERT_IMP(a_count_bound, 1'b1, (vc_q <= CountW'(STACK_DEPTH)) && (oc_q <= CountW'(STACK_DEPTH)), "stack count beyond depth")
  `IES_ASSERT_NEXT(a_emit_clears, out_load, out_valid_o && (vc_q == '0) && (oc_q == '0) && (err_q == ST_OK), "end did not clear the stacks")
  `IES_ASSERT_IMP(a_div_nonzero, div_req.start, div_req.divisor != '0, "divider started with zero divisor")
  `IES_ASSERT_IMP(a_err_zero_result, out_valid_o && (status_o != ST_OK), result_o == '0, "error result not zero")

endmodule

FILE: tb/infix_expression_evaluator_tb.sv
`timescale 1ns / 100ps

module infix_expression_evaluator_tb;
  import ies_pkg::*;

  localparam int unsigned Depth       = StackDepthDef;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned TargetItems = 1250;
  localparam int unsigned HoldCycles  = 800;
  localparam int unsigned DrainWait   = 200;
  localparam int unsigned ActTop      = 2**3 - 1;

  typedef struct packed {
    logic [2:0]         act;
    logic [NumberW-1:0] num;
    logic [1:0]         opc;
  } token_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    status_e           st;
  } outcome_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [2:0]               action_i    = '0;
  logic [NumberW-1:0]       number_i    = '0;
  logic [1:0]               op_code_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ValueW-1:0] result_o;
  logic [1:0]               status_o;

  token_t      token_q[$];
  outcome_t    expr_results_q[$];
  int unsigned n_total, n_counted, acc_cnt, mismatches, cycles, hold_left;
  bit          hold_done, noise_on;

  // predictor copy of the evaluator state
  logic [ValueW-1:0] vals [Depth];
  logic [OperW-1:0]  opers [Depth];
  int unsigned       n_vals, n_opers;
  status_e           first_err = ST_OK;

  infix_expression_evaluator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .number_i   (number_i),
    .op_code_i  (op_code_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result_o),
    .status_o   (status_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------

  function automatic logic [ValueW-1:0] div_trunc(logic [ValueW-1:0] a, logic [ValueW-1:0] b);
    logic [ValueW-1:0] ma, mb, q;
    ma = a[ValueW-1] ? (32'd0 - a) : a;
    mb = b[ValueW-1] ? (32'd0 - b) : b;
    q  = ma / mb;
    return (a[ValueW-1] ^ b[ValueW-1]) ? (32'd0 - q) : q;
  endfunction

  function automatic void apply_oper(logic [OperW-1:0] code);
    logic [ValueW-1:0] lhs, rhs, r;
    if (n_vals < 2) begin
      first_err = ST_MALFORMED;
      return;
    end
    rhs = vals[n_vals-1];
    lhs = vals[n_vals-2];
    case (code[1:0])
      OP_ADD: r = lhs + rhs;
      OP_SUB: r = lhs - rhs;
      OP_MUL: r = lhs * rhs;
      default: begin
        if (rhs == '0) begin
          first_err = ST_DIV_ZERO;
          return;
        end
        r = div_trunc(lhs, rhs);
      end
    endcase
    n_vals--;
    vals[n_vals-1] = r;
  endfunction

  function automatic void push_oper(logic [OperW-1:0] code);
    if (n_opers >= Depth) begin
      first_err = ST_OVERFLOW;
    end else begin
      opers[n_opers] = code;
      n_opers++;
    end
  endfunction

  function automatic logic [OperW-1:0] pop_oper();
    n_opers--;
    return opers[n_opers];
  endfunction

  function automatic void eval_token(token_t t);
    logic [OperW-1:0]  top;
    logic [ValueW-1:0] value;
    bit                busy;
    if (t.act == ACT_END) begin
      value = '0;
      while (first_err == ST_OK && n_opers > 0) begin
        top = pop_oper();
        if (top == OperOpen) first_err = ST_MALFORMED;
        else apply_oper(top);
      end
      if (first_err == ST_OK && n_vals != 1) first_err = ST_MALFORMED;
      if (first_err == ST_OK) value = vals[0];
      expr_results_q.push_back(outcome_t'{value, first_err});
      n_vals    = 0;
      n_opers   = 0;
      first_err = ST_OK;
      return;
    end
    if (first_err != ST_OK) return;
    case (t.act)
      ACT_OPERAND: begin
        if (n_vals >= Depth) begin
          first_err = ST_OVERFLOW;
        end else begin
          vals[n_vals] = {1'b0, t.num};
          n_vals++;
        end
      end
      ACT_OPEN: push_oper(OperOpen);
      ACT_CLOSE: begin
        busy = 1'b1;
        while (busy) begin
          if (n_opers == 0) begin
            first_err = ST_MALFORMED;
            busy = 1'b0;
          end else begin
            top = pop_oper();
            if (top == OperOpen) begin
              busy = 1'b0;
            end else begin
              apply_oper(top);
              if (first_err != ST_OK) busy = 1'b0;
            end
          end
        end
      end
      ACT_OPER: begin
        busy = 1'b1;
        while (busy && first_err == ST_OK && n_opers > 0) begin
          top = opers[n_opers-1];
          // bit 1 of the operator code marks the * / precedence level
          if (top == OperOpen || top[1] < t.opc[1]) begin
            busy = 1'b0;
          end else begin
            top = pop_oper();
            apply_oper(top);
          end
        end
        if (first_err == ST_OK) push_oper({1'b0, t.opc});
      end
      default: ;
    endcase
  endfunction

  // ---------------- stimulus ----------------

  function automatic void put(logic [2:0] a, logic [NumberW-1:0] n, logic [1:0] o);
    token_t t;
    if (noise_on && $urandom_range(99) < 3) begin
      t.act = 3'($urandom_range(ACT_END + 1, ActTop));
      t.num = NumberW'($urandom);
      t.opc = 2'($urandom);
      token_q.push_back(t);
    end
    t.act = a;
    t.num = n;
    t.opc = o;
    token_q.push_back(t);
    if (a <= ACT_END) n_counted++;
  endfunction

  function automatic void add_num(logic [NumberW-1:0] n);
    logic [1:0] filler;
    filler = 2'($urandom);
    put(ACT_OPERAND, n, filler);
  endfunction

  function automatic void add_op(logic [1:0] o);
    logic [NumberW-1:0] filler;
    filler = NumberW'($urandom);
    put(ACT_OPER, filler, o);
  endfunction

  function automatic void add_tok(logic [2:0] a);
    logic [NumberW-1:0] n;
    logic [1:0]         o;
    n = NumberW'($urandom);
    o = 2'($urandom);
    put(a, n, o);
  endfunction

  function automatic logic [NumberW-1:0] rand_num();
    logic [NumberW-1:0] n;
    case ($urandom_range(9))
      0:       n = '0;
      1:       n = '1;
      2, 3:    n = NumberW'($urandom);
      default: n = NumberW'($urandom_range(12));
    endcase
    return n;
  endfunction

  function automatic void gen_expr(int depth);
    int nterms;
    nterms = $urandom_range(1, 4);
    for (int i = 0; i < nterms; i++) begin
      if (i > 0) add_op(2'($urandom_range(OP_DIV)));
      if (depth > 0 && $urandom_range(3) == 0) begin
        add_tok(ACT_OPEN);
        gen_expr(depth - 1);
        add_tok(ACT_CLOSE);
      end else begin
        add_num(rand_num());
      end
    end
  endfunction

  function automatic int unsigned phase();
    return (acc_cnt * 3) / n_total;
  endfunction

  initial begin
    int unsigned kind, nest;

    // INT_MIN / -1 wraps back to INT_MIN
    add_num(NumberW'(65536)); add_op(OP_MUL); add_num(NumberW'(32768)); add_op(OP_DIV);
    add_tok(ACT_OPEN); add_num('0); add_op(OP_SUB); add_num(NumberW'(1)); add_tok(ACT_CLOSE);
    add_tok(ACT_END);
    // divide by zero, then tokens dropped until end
    add_num('1); add_op(OP_ADD); add_num('0); add_op(OP_DIV); add_num('0);
    add_op(OP_ADD); add_num(NumberW'(9)); add_tok(ACT_END);
    // unmatched close
    add_num(NumberW'(4)); add_tok(ACT_CLOSE); add_tok(ACT_END);
    // open bracket left at end
    add_tok(ACT_OPEN); add_tok(ACT_END);
    // empty expression
    add_tok(ACT_END);
    // reduce with a single value
    add_op(OP_SUB); add_num(NumberW'(5)); add_tok(ACT_END);

    noise_on = 1'b1;
    while (n_counted < TargetItems) begin
      kind = $urandom_range(99);
      if (kind < 72) begin
        gen_expr(2);
      end else if (kind < 84) begin
        gen_expr(1);
        repeat ($urandom_range(1, 3)) add_tok(3'($urandom_range(ACT_OPER)));
        gen_expr(0);
      end else if (kind < 92) begin
        repeat ($urandom_range(10)) add_tok(3'($urandom_range(ActTop)));
      end else if (kind < 96) begin
        // value stack near and past full
        repeat ($urandom_range(30, 36)) add_num(rand_num());
        gen_expr(0);
      end else begin
        // deep nesting, operator stack near and past full
        nest = $urandom_range(14, 17);
        repeat (nest) begin
          add_num(rand_num());
          add_op(2'($urandom_range(OP_DIV)));
          add_tok(ACT_OPEN);
        end
        gen_expr(0);
        repeat (nest) add_tok(ACT_CLOSE);
      end
      add_tok(ACT_END);
    end
    n_total = token_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (acc_cnt < n_total) @(posedge clk_i);
    while (expr_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("infix_expression_evaluator_tb: PASS");
    end else begin
      $display("infix_expression_evaluator_tb: FAIL");
    end
    $finish;
  end

  // ---------------- request driver ----------------

  always @(posedge clk_i or negedge rst_ni) begin : driver
    token_t      nxt;
    int unsigned idle_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        eval_token(token_t'{action_i, number_i, op_code_i});
        acc_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        case (phase())
          0:       idle_pct = 15;
          1:       idle_pct = 66;
          default: idle_pct = 0;
        endcase
        if (token_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = token_q.pop_front();
          in_valid_i <= 1'b1;
          action_i   <= nxt.act;
          number_i   <= nxt.num;
          op_code_i  <= nxt.opc;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off late in the run so the result slot fills and input backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && acc_cnt >= (2 * n_total) / 3 + 10) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // ---------------- result monitor ----------------

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    outcome_t    want;
    int unsigned stall_pct;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expr_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: result %0d status %0d with nothing expected",
                     $time, result_o, status_o);
        end else begin
          want = expr_results_q.pop_front();
          if (result_o !== want.value || status_o !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t: expected result %0d status %0d, got result %0d status %0d",
                       $time, $signed(want.value), want.st, result_o, status_o);
          end
        end
      end
      case (phase())
        0:       stall_pct = 66;
        1:       stall_pct = 15;
        default: stall_pct = 0;
      endcase
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("infix_expression_evaluator_tb: FAIL");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ies_pkg.sv
rtl/core/ies_ram.sv
rtl/core/ies_div.sv
rtl/core/infix_expression_evaluator.sv
tb/infix_expression_evaluator_tb.sv
